// ----- rtl/pidq_pkg.sv -----
// Shared types and fixed field widths for the positional insert/delete queue.
// No dependencies; imported by every module of the block.
package pidq_pkg;

   localparam int OP_BITS     = 2;
   localparam int VALUE_BITS  = 32;
   localparam int POS_BITS    = 7;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;
   localparam int EXT_BITS    = 64;
   localparam int BEAT_BITS   = 48;

   typedef enum logic [OP_BITS-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_INSERT = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CM_HOLD  = 2'd0,
      CM_LOAD  = 2'd1,
      CM_LEFT  = 2'd2,
      CM_RIGHT = 2'd3
   } cell_mode_type;

   typedef struct packed {
      logic       grow;
      logic       shrink;
      status_type status;
   } edit_type;

endpackage

// ----- rtl/pidq_cell.sv -----
// One storage cell of the queue chain: holds one entry and either keeps it or takes its next
// value from the request, its front-side or its back-side neighbor. Uses pidq_pkg.
module pidq_cell
   import pidq_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  cell_mode_type         mode,
   input  logic [DATA_WIDTH-1:0] load_value,
   input  logic [DATA_WIDTH-1:0] left_value,
   input  logic [DATA_WIDTH-1:0] right_value,
   output logic [DATA_WIDTH-1:0] data,
   output logic [DATA_WIDTH-1:0] data_next
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      unique case (mode)
         CM_HOLD:  data_in = data_ff;
         CM_LOAD:  data_in = load_value;
         CM_LEFT:  data_in = left_value;
         CM_RIGHT: data_in = right_value;
         default:  data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign data_next = data_in;

endmodule

// ----- rtl/pidq_ctrl.sv -----
// Request decode: range and fullness checks, edit target and next count.
// Uses pidq_pkg.
module pidq_ctrl
   import pidq_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  op_type                       op,
   input  logic [POS_BITS-1:0]          position,
   input  logic [$clog2(DEPTH+1)-1:0]   count,
   output edit_type                     edit,
   output logic [$clog2(DEPTH)-1:0]     target,
   output logic [$clog2(DEPTH+1)-1:0]   count_next
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;

   logic [CMP_W-1:0] pos_c;
   logic [CMP_W-1:0] cnt_c;
   logic [CMP_W-1:0] pos_m1;
   logic             full;
   logic             empty;

   assign pos_c  = CMP_W'(position);
   assign cnt_c  = CMP_W'(count);
   assign pos_m1 = pos_c - CMP_W'(1);
   assign full   = (cnt_c == CMP_W'(DEPTH));
   assign empty  = (cnt_c == '0);

   always_comb begin
      edit.grow   = 1'b0;
      edit.shrink = 1'b0;
      edit.status = ST_DONE;
      target      = '0;
      unique case (op)
         OP_PUSH: begin
            if (full) edit.status = ST_FULL;
            else begin
               edit.grow = 1'b1;
               target    = IDX_W'(cnt_c);
            end
         end
         OP_POP: begin
            if (empty) edit.status = ST_RANGE;
            else edit.shrink = 1'b1;
         end
         OP_INSERT: begin
            priority if (full) edit.status = ST_FULL;
            else if (pos_c == '0 || pos_c > cnt_c + CMP_W'(1)) edit.status = ST_RANGE;
            else begin
               edit.grow = 1'b1;
               target    = IDX_W'(pos_m1);
            end
         end
         OP_DELETE: begin
            if (pos_c == '0 || pos_c > cnt_c) edit.status = ST_RANGE;
            else begin
               edit.shrink = 1'b1;
               target      = IDX_W'(pos_m1);
            end
         end
         default: edit.status = ST_RANGE;
      endcase
   end

   always_comb begin
      priority if (edit.grow) count_next = count + CNT_W'(1);
      else if (edit.shrink) count_next = count - CNT_W'(1);
      else count_next = count;
   end

endmodule

// ----- rtl/positional_insert_delete_queue_top.sv -----
// Positional insert/delete queue: top level with the cell chain and result register.
// Depends on pidq_pkg, pidq_ctrl and pidq_cell.
//
// An ordered queue held in a row of DEPTH cells, front in cell 0. Push, pop,
// insert at a 1-based position and delete at a 1-based position update every
// cell in the same clock: each cell loads, holds, or takes its neighbor's
// entry, so one request beat is taken per cycle while the result register
// can take it. A request is accepted whenever the result register is empty
// or its beat is being taken, and the result beat (status, front value, new
// count) appears the cycle after. Refused requests (full store, bad position,
// empty queue) leave the queue unchanged. Entries beyond the count are never reported.
module positional_insert_delete_queue_top
   import pidq_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [BEAT_BITS-1:0] req_tdata,  // operation[1:0], value[33:2], position[40:34]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BEAT_BITS-1:0] rsp_tdata   // status[1:0], front_value[33:2], count[40:34]
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   logic                    accept;
   op_type                  req_op;
   logic [VALUE_BITS-1:0]   req_value;
   logic [POS_BITS-1:0]     req_position;
   logic [DATA_WIDTH-1:0]   store_value;

   edit_type                edit;
   logic [IDX_W-1:0]        target;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic [CNT_W-1:0]        count_calc;

   logic [DATA_WIDTH-1:0]   cell_data [DEPTH];
   logic [DATA_WIDTH-1:0]   cell_next [DEPTH];
   cell_mode_type           cell_mode [DEPTH];

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [BEAT_BITS-1:0]    rsp_data_ff;
   logic [BEAT_BITS-1:0]    rsp_data_in;
   logic [EXT_BITS-1:0]     front_wide;
   logic [VALUE_BITS-1:0]   front_value;

   assign req_tready   = !rsp_valid_ff || rsp_tready;
   assign accept       = req_tvalid && req_tready;
   assign req_op       = op_type'(req_tdata[1:0]);
   assign req_value    = req_tdata[33:2];
   assign req_position = req_tdata[40:34];

   logic [EXT_BITS-1:0] value_wide;
   assign value_wide  = EXT_BITS'(signed'(req_value));
   assign store_value = value_wide[DATA_WIDTH-1:0];

   pidq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .op         (req_op),
      .position   (req_position),
      .count      (count_ff),
      .edit       (edit),
      .target     (target),
      .count_next (count_calc)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_value;
      logic [DATA_WIDTH-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_value = cell_data[i];
      end else begin : g_mid_r
         assign right_value = cell_data[i+1];
      end

      always_comb begin
         priority if (!accept) cell_mode[i] = CM_HOLD;
         else if (edit.grow && IDX_W'(i) == target) cell_mode[i] = CM_LOAD;
         else if (edit.grow && IDX_W'(i) > target) cell_mode[i] = CM_LEFT;
         else if (edit.shrink && IDX_W'(i) >= target) cell_mode[i] = CM_RIGHT;
         else cell_mode[i] = CM_HOLD;
      end

      pidq_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
         .clock       (clock),
         .mode        (cell_mode[i]),
         .load_value  (store_value),
         .left_value  (left_value),
         .right_value (right_value),
         .data        (cell_data[i]),
         .data_next   (cell_next[i])
      );
   end

   assign count_in    = accept ? count_calc : count_ff;
   assign front_wide  = EXT_BITS'(signed'(cell_next[0]));
   assign front_value = (count_in == '0) ? '0 : front_wide[VALUE_BITS-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, COUNT_BITS'(count_in), front_value, edit.status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request gave no result");

   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      accept && edit.status != ST_DONE |=> count_ff == $past(count_ff))
      else $error("refused request changed count");

   a_result_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[40:34] == COUNT_BITS'(count_ff))
      else $error("reported count differs from held count");

endmodule
